### rtl/dmt_pkg.sv
package dmt_pkg;

   localparam int MAX_TIMERS     = 2;
   localparam int NUM_TIMERS_DEF = 2;

   localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
   localparam logic [31:0] MASK_16   = 32'h0000_FFFF;
   localparam logic [31:0] KEEP_BYTE = 32'hFFFF_FF00;
   localparam logic [31:0] KEEP_HALF = 32'hFFFF_0000;
   localparam logic [7:0]  CTL_RESET = 8'h20;

   // control register bit positions
   localparam int CTL_ONESHOT  = 0;
   localparam int CTL_32BIT    = 1;
   localparam int CTL_DIV_LO   = 2;
   localparam int CTL_IE       = 5;
   localparam int CTL_PERIODIC = 6;
   localparam int CTL_ENABLE   = 7;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_READ    = 2'd1,
      OP_WRITE   = 2'd2,
      OP_INVALID = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_LOAD    = 3'd0,
      REG_VALUE   = 3'd1,
      REG_CONTROL = 3'd2,
      REG_INTCLR  = 3'd3,
      REG_RIS     = 3'd4,
      REG_MIS     = 3'd5,
      REG_BGLOAD  = 3'd6,
      REG_NONE    = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      SIZE_BYTE    = 2'd0,
      SIZE_HALF    = 2'd1,
      SIZE_WORD    = 2'd2,
      SIZE_INVALID = 2'd3
   } size_type;

   typedef enum logic [1:0] {
      DIV_1     = 2'd0,
      DIV_16    = 2'd1,
      DIV_256   = 2'd2,
      DIV_1_ALT = 2'd3
   } div_type;

   // decoded beat, shared by all timers
   typedef struct packed {
      logic        tick;
      logic        err;
      logic        rd;
      logic        wr_limit;
      logic        wr_ctrl;
      logic        wr_clr;
      logic        wr_bg;
      logic [31:0] keep;
      logic [31:0] wval;
   } access_type;

   typedef struct packed {
      logic [31:0] limit;
      logic [7:0]  ctrl;
      logic [31:0] count;
      logic        raw;
   } timer_state_type;

   function automatic logic [31:0] start_value(input logic [31:0] limit,
                                               input logic [7:0]  ctrl);
      logic [31:0] v;
      if (!ctrl[CTL_ONESHOT] && !ctrl[CTL_PERIODIC]) v = ALL_ONES;
      else v = limit;
      if (!ctrl[CTL_32BIT]) v = v & MASK_16;
      return v;
   endfunction

endpackage

### rtl/dual_mode_timer_registers_unit.sv
// Channel | Ports                                        | Direction
// req     | req_valid/ready, operation..write_data      | in, one beat per tick or access
// rsp     | rsp_valid/ready, read_data..irq_timer1      | out, one beat per req beat
//
// One rsp beat per req beat, in order. A beat is held in the input
// register and then resolved into the result register, one beat per cycle
// through the pair while rsp is not stalled.
// Reset (synchronous, active high) restores every timer register and empties
// both stages. A stalled rsp holds the result register; the input register
// drains into it once it frees, so req_ready drops only when both are full.
module dual_mode_timer_registers_unit #(
   parameter int NUM_TIMERS = dmt_pkg::NUM_TIMERS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic        req_timer_select,
   input  logic [2:0]  req_reg_index,
   input  logic [1:0]  req_byte_offset,
   input  logic [1:0]  req_access_size,
   input  logic [31:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_access_error,
   output logic        rsp_irq_timer0,
   output logic        rsp_irq_timer1
);

   // input register
   logic        in_vld_ff, in_vld_in;
   logic [1:0]  op_ff;
   logic        tsel_ff;
   logic [2:0]  idx_ff;
   logic [1:0]  lane_ff;
   logic [1:0]  size_ff;
   logic [31:0] data_ff;

   // result register
   logic        out_vld_ff, out_vld_in;
   logic [31:0] rdata_ff;
   logic        err_ff;
   logic        irq0_ff;
   logic        irq1_ff;

   logic        advance;
   logic        req_fire;
   logic        timer_present;

   dmt_pkg::access_type      acc;
   dmt_pkg::timer_state_type tstate [dmt_pkg::MAX_TIMERS];
   logic                     irq_next [dmt_pkg::MAX_TIMERS];

   dmt_pkg::timer_state_type cur;
   logic [31:0] reg_val;
   logic [31:0] shifted;
   logic [31:0] rd_val;

   // move the held beat into the result register whenever it is free or leaving
   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_vld_in  = req_fire || (in_vld_ff && !advance);
   assign out_vld_in = advance || (out_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // capture the request payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_operation;
         tsel_ff <= req_timer_select;
         idx_ff  <= req_reg_index;
         lane_ff <= req_byte_offset;
         size_ff <= req_access_size;
         data_ff <= req_write_data;
      end
   end

   assign timer_present = (32'(tsel_ff) < NUM_TIMERS);

   dmt_decode u_decode (
      .op_valid      (in_vld_ff),
      .operation     (op_ff),
      .timer_present (timer_present),
      .reg_index     (idx_ff),
      .byte_offset   (lane_ff),
      .access_size   (size_ff),
      .write_data    (data_ff),
      .acc           (acc)
   );

   // one timer per slot; absent slots read as all zeros with no irq
   for (genvar i = 0; i < dmt_pkg::MAX_TIMERS; i++) begin : g_timer
      if (i < NUM_TIMERS) begin : g_on
         dmt_timer u_timer (
            .clock    (clock),
            .reset    (reset),
            .step_en  (advance),
            .sel      (tsel_ff == 1'(i)),
            .acc      (acc),
            .state    (tstate[i]),
            .irq_next (irq_next[i])
         );
      end else begin : g_off
         assign tstate[i]   = '0;
         assign irq_next[i] = 1'b0;
      end
   end

   // register read path: select, drop the lane, mask to the access size
   assign cur = tstate[tsel_ff];

   always_comb begin
      case (dmt_pkg::reg_index_type'(idx_ff))
         dmt_pkg::REG_LOAD,
         dmt_pkg::REG_BGLOAD:  reg_val = cur.limit;
         dmt_pkg::REG_VALUE:   reg_val = cur.count;
         dmt_pkg::REG_CONTROL: reg_val = {24'd0, cur.ctrl};
         dmt_pkg::REG_RIS:     reg_val = {31'd0, cur.raw};
         dmt_pkg::REG_MIS:     reg_val = {31'd0, cur.raw & cur.ctrl[dmt_pkg::CTL_IE]};
         default:              reg_val = '0;
      endcase
   end

   assign shifted = reg_val >> {lane_ff, 3'b000};

   always_comb begin
      case (dmt_pkg::size_type'(size_ff))
         dmt_pkg::SIZE_BYTE: rd_val = shifted & 32'h0000_00FF;
         dmt_pkg::SIZE_HALF: rd_val = shifted & dmt_pkg::MASK_16;
         default:            rd_val = shifted;
      endcase
   end

   // result register: irq lines reflect timer state after this beat
   always_ff @(posedge clock) begin
      if (advance) begin
         rdata_ff <= acc.rd ? rd_val : 32'd0;
         err_ff   <= acc.err;
         irq0_ff  <= irq_next[0];
         irq1_ff  <= irq_next[1];
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_read_data    = rdata_ff;
   assign rsp_access_error = err_ff;
   assign rsp_irq_timer0   = irq0_ff;
   assign rsp_irq_timer1   = irq1_ff;

endmodule

### rtl/dmt_decode.sv
module dmt_decode (
   input  logic                    op_valid,
   input  logic [1:0]              operation,
   input  logic                    timer_present,
   input  logic [2:0]              reg_index,
   input  logic [1:0]              byte_offset,
   input  logic [1:0]              access_size,
   input  logic [31:0]             write_data,
   output dmt_pkg::access_type     acc
);

   logic [63:0] keep_wide;
   logic [31:0] keep_base;
   logic [4:0]  shamt;
   logic        bad_access;
   logic        reg_err;

   assign shamt = {byte_offset, 3'b000};

   always_comb begin
      case (dmt_pkg::size_type'(access_size))
         dmt_pkg::SIZE_BYTE: keep_base = dmt_pkg::KEEP_BYTE;
         dmt_pkg::SIZE_HALF: keep_base = dmt_pkg::KEEP_HALF;
         default:            keep_base = '0;
      endcase
   end

   // rotate the kept-bit mask with the lane
   assign keep_wide = {keep_base, keep_base} << shamt;

   assign bad_access = (dmt_pkg::op_type'(operation) == dmt_pkg::OP_INVALID)
                       || (dmt_pkg::size_type'(access_size) == dmt_pkg::SIZE_INVALID)
                       || !timer_present;

   always_comb begin
      acc          = '0;
      acc.keep     = keep_wide[63:32];
      acc.wval     = write_data << shamt;
      reg_err      = 1'b0;
      if (dmt_pkg::op_type'(operation) == dmt_pkg::OP_TICK) begin
         acc.tick = op_valid;
      end else if (bad_access) begin
         acc.err = 1'b1;
      end else if (dmt_pkg::op_type'(operation) == dmt_pkg::OP_READ) begin
         case (dmt_pkg::reg_index_type'(reg_index))
            dmt_pkg::REG_INTCLR, dmt_pkg::REG_NONE: reg_err = 1'b1;
            default:                                reg_err = 1'b0;
         endcase
         acc.err = reg_err;
         acc.rd  = !reg_err;
      end else begin
         case (dmt_pkg::reg_index_type'(reg_index))
            dmt_pkg::REG_LOAD:    acc.wr_limit = op_valid;
            dmt_pkg::REG_VALUE:   reg_err = 1'b0;
            dmt_pkg::REG_CONTROL: acc.wr_ctrl = op_valid;
            dmt_pkg::REG_INTCLR:  acc.wr_clr = op_valid;
            dmt_pkg::REG_BGLOAD:  acc.wr_bg = op_valid;
            default:              reg_err = 1'b1;
         endcase
         acc.err = reg_err;
      end
   end

endmodule

### rtl/dmt_timer.sv
module dmt_timer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  logic                        sel,
   input  dmt_pkg::access_type         acc,
   output dmt_pkg::timer_state_type    state,
   output logic                        irq_next
);

   logic [31:0] limit_ff, limit_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [31:0] count_ff, count_in;
   logic [7:0]  pre_ff, pre_in;
   logic        raw_ff, raw_in;
   logic [31:0] merged_limit;
   logic [7:0]  merged_ctrl;
   logic        pre_done;

   assign merged_limit = (limit_ff & acc.keep) | (acc.wval & ~acc.keep);
   assign merged_ctrl  = (ctrl_ff & acc.keep[7:0]) | (acc.wval[7:0] & ~acc.keep[7:0]);

   // prescaler terminal count
   always_comb begin
      case (dmt_pkg::div_type'(ctrl_ff[dmt_pkg::CTL_DIV_LO +: 2]))
         dmt_pkg::DIV_16:  pre_done = (pre_ff >= 8'd15);
         dmt_pkg::DIV_256: pre_done = (pre_ff == 8'hFF);
         default:          pre_done = 1'b1;
      endcase
   end

   always_comb begin
      limit_in = limit_ff;
      ctrl_in  = ctrl_ff;
      count_in = count_ff;
      pre_in   = pre_ff;
      raw_in   = raw_ff;
      if (step_en && acc.tick) begin
         if (ctrl_ff[dmt_pkg::CTL_ENABLE]) begin
            if (!pre_done) begin
               pre_in = pre_ff + 8'd1;
            end else begin
               pre_in = '0;
               if (count_ff > 32'd1) begin
                  count_in = count_ff - 32'd1;
               end else begin
                  raw_in = 1'b1;
                  if (ctrl_ff[dmt_pkg::CTL_ONESHOT]) begin
                     count_in = '0;
                     ctrl_in  = ctrl_ff & ~(8'd1 << dmt_pkg::CTL_ENABLE);
                  end else begin
                     count_in = dmt_pkg::start_value(limit_ff, ctrl_ff);
                  end
               end
            end
         end
      end else if (step_en && sel) begin
         if (acc.wr_limit) begin
            limit_in = merged_limit;
            if (ctrl_ff[dmt_pkg::CTL_ENABLE]) begin
               count_in = dmt_pkg::start_value(merged_limit, ctrl_ff);
               pre_in   = '0;
            end
         end
         if (acc.wr_bg) begin
            limit_in = merged_limit;
         end
         if (acc.wr_ctrl) begin
            ctrl_in = merged_ctrl;
            if (merged_ctrl[dmt_pkg::CTL_ENABLE]) begin
               count_in = dmt_pkg::start_value(limit_ff, merged_ctrl);
               pre_in   = '0;
            end
         end
         if (acc.wr_clr) begin
            raw_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= dmt_pkg::ALL_ONES;
         ctrl_ff  <= dmt_pkg::CTL_RESET;
         count_ff <= '0;
         pre_ff   <= '0;
         raw_ff   <= 1'b0;
      end else begin
         limit_ff <= limit_in;
         ctrl_ff  <= ctrl_in;
         count_ff <= count_in;
         pre_ff   <= pre_in;
         raw_ff   <= raw_in;
      end
   end

   assign state.limit = limit_ff;
   assign state.ctrl  = ctrl_ff;
   assign state.count = count_ff;
   assign state.raw   = raw_ff;
   assign irq_next    = raw_in & ctrl_in[dmt_pkg::CTL_IE];

endmodule
